// ----- hdl/cbp_pkg.sv -----
// Shared types, constants and colour tables for the colour bar pattern generator.
// No dependencies; imported by every module of the block.

package cbp_pkg;

    localparam int DEF_MAX_WIDTH    = 4096;
    localparam int DEF_MARKER_WIDTH = 8;

    localparam int COL_W     = 12;
    localparam int ROW_W     = 12;
    localparam int FRAME_W   = 24;
    localparam int LINE_W    = 13;
    localparam int SAMPLE_W  = 8;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_USE_BT601  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NO_OFFSET  = 4'd2;
    localparam logic [LINE_W-1:0]      LINE_WIDTH_RST = 13'd1280;

    // Marker step is width/120 + 1, taken by a reciprocal multiply
    localparam int STEP_DIV    = 120;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 18;
    localparam logic [RECIP_W-1:0] RECIP_STEP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + STEP_DIV - 1) / STEP_DIV);

    // Remainder unit: dividend bits retired per pipeline stage
    localparam int DIV_BITS_PER_STAGE = 4;

    // Colour levels
    localparam logic [SAMPLE_W-1:0] LEVEL_HI    = 8'd235;
    localparam logic [SAMPLE_W-1:0] LEVEL_LO    = 8'd16;
    localparam logic [SAMPLE_W-1:0] MARKER_LUMA = 8'd235;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = 8'd255;

    // Fixed-point matrix: 24 fraction bits
    localparam int FRAC_BITS = 24;
    localparam int COEF_W    = 25;
    localparam int PROD_W    = COEF_W + SAMPLE_W + 1;
    localparam int ACC_W     = 36;

    localparam longint QC_SCALE = 64'sd16777216;
    localparam longint QC_HALF  = 64'sd127500;
    localparam longint QC_DEN   = 64'sd255000;

    localparam longint QC_46742  = (64'sd46742  * QC_SCALE + QC_HALF) / QC_DEN;
    localparam longint QC_157243 = (64'sd157243 * QC_SCALE + QC_HALF) / QC_DEN;
    localparam longint QC_15874  = (64'sd15874  * QC_SCALE + QC_HALF) / QC_DEN;
    localparam longint QC_25805  = (64'sd25805  * QC_SCALE + QC_HALF) / QC_DEN;
    localparam longint QC_86336  = (64'sd86336  * QC_SCALE + QC_HALF) / QC_DEN;
    localparam longint QC_112141 = (64'sd112141 * QC_SCALE + QC_HALF) / QC_DEN;
    localparam longint QC_112000 = (64'sd112000 * QC_SCALE + QC_HALF) / QC_DEN;
    localparam longint QC_102560 = (64'sd102560 * QC_SCALE + QC_HALF) / QC_DEN;
    localparam longint QC_9440   = (64'sd9440   * QC_SCALE + QC_HALF) / QC_DEN;
    localparam longint QC_65481  = (64'sd65481  * QC_SCALE + QC_HALF) / QC_DEN;
    localparam longint QC_128553 = (64'sd128553 * QC_SCALE + QC_HALF) / QC_DEN;
    localparam longint QC_24966  = (64'sd24966  * QC_SCALE + QC_HALF) / QC_DEN;
    localparam longint QC_37797  = (64'sd37797  * QC_SCALE + QC_HALF) / QC_DEN;
    localparam longint QC_74203  = (64'sd74203  * QC_SCALE + QC_HALF) / QC_DEN;
    localparam longint QC_93786  = (64'sd93786  * QC_SCALE + QC_HALF) / QC_DEN;
    localparam longint QC_18214  = (64'sd18214  * QC_SCALE + QC_HALF) / QC_DEN;

    // [0 = BT.709, 1 = BT.601][Y, Cb, Cr][R, G, B]
    localparam logic signed [COEF_W-1:0] COEF [2][3][3] = '{
        '{
            '{ COEF_W'(QC_46742),   COEF_W'(QC_157243),  COEF_W'(QC_15874)  },
            '{ COEF_W'(-QC_25805),  COEF_W'(-QC_86336),  COEF_W'(QC_112141) },
            '{ COEF_W'(QC_112000),  COEF_W'(-QC_102560), COEF_W'(-QC_9440)  }
        },
        '{
            '{ COEF_W'(QC_65481),   COEF_W'(QC_128553),  COEF_W'(QC_24966)  },
            '{ COEF_W'(-QC_37797),  COEF_W'(-QC_74203),  COEF_W'(QC_112000) },
            '{ COEF_W'(QC_112000),  COEF_W'(-QC_93786),  COEF_W'(-QC_18214) }
        }
    };

    localparam logic signed [ACC_W-1:0] OFF_LUMA   = ACC_W'(64'sd16 <<< FRAC_BITS);
    localparam logic signed [ACC_W-1:0] OFF_CHROMA = ACC_W'(64'sd128 <<< FRAC_BITS);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
        logic [FRAME_W-1:0] frame_number;
    } t_in;

    typedef struct packed {
        logic [SAMPLE_W-1:0] luma;
        logic [SAMPLE_W-1:0] chroma_blue;
        logic [SAMPLE_W-1:0] chroma_red;
        logic                chroma_valid;
    } t_out;

    // Per-item fields that ride alongside the remainder unit
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             cv;
        logic [2:0]       bar_y;
        logic [2:0]       bar_c;
    } t_side;

    // Index 0 = R, 1 = G, 2 = B
    typedef logic [2:0][SAMPLE_W-1:0] t_rgb;

    // Bar colours: R off on bars 2,3,6,7; G off on 4..7; B off on odd bars
    function automatic t_rgb bar_rgb(input logic [2:0] bar);
        t_rgb c;
        c[0] = bar[1] ? LEVEL_LO : LEVEL_HI;
        c[1] = bar[2] ? LEVEL_LO : LEVEL_HI;
        c[2] = bar[0] ? LEVEL_LO : LEVEL_HI;
        return c;
    endfunction

endpackage

// ----- hdl/cbp_pipe_ctrl.sv -----
// Valid bits and per-stage load enables for the pattern pipeline.
// Uses cbp_pkg; a stage loads when it is empty or the stage after it moves.

module cbp_pipe_ctrl
    import cbp_pkg::*;
#(
    parameter int NUM_STAGES = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_stall,
    output logic                  o_in_stall,
    output logic [NUM_STAGES-1:0] o_vld,
    output logic [NUM_STAGES-1:0] o_en
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_en;

    // Bubbles collapse: a stage moves if it is empty or its successor moves
    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_stall = !w_en[0];
    assign o_vld      = r_vld;
    assign o_en       = w_en;

endmodule

// ----- hdl/cbp_mod_div.sv -----
// Pipelined restoring remainder unit: marker start = product mod line width.
// Uses cbp_pkg for the side-band item type; stage enables come from cbp_pipe_ctrl.

module cbp_mod_div
    import cbp_pkg::*;
#(
    parameter int PROD_BITS  = 30,
    parameter int WIDTH_BITS = 13,
    parameter int NUM_DIV    = 8
) (
    input  logic                  i_clk,
    input  logic [NUM_DIV-1:0]    i_en,
    input  logic [WIDTH_BITS-1:0] i_width,
    input  logic [PROD_BITS-1:0]  i_prod,
    input  t_side                 i_side,
    output logic [WIDTH_BITS-1:0] o_rem,
    output t_side                 o_side
);

    localparam int DVW = NUM_DIV * DIV_BITS_PER_STAGE;

    logic [WIDTH_BITS-1:0] r_rem  [NUM_DIV];
    logic [DVW-1:0]        r_dvd  [NUM_DIV];
    t_side                 r_side [NUM_DIV];

    for (genvar j = 0; j < NUM_DIV; j++) begin : g_stage
        logic [WIDTH_BITS-1:0] w_rem_in;
        logic [DVW-1:0]        w_dvd_in;
        t_side                 w_side_in;
        logic [WIDTH_BITS-1:0] n_rem;
        logic [DVW-1:0]        n_dvd;

        if (j == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_dvd_in  = DVW'(i_prod);
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_rem_in  = r_rem[j-1];
            assign w_dvd_in  = r_dvd[j-1];
            assign w_side_in = r_side[j-1];
        end

        // Shift in dividend bits MSB first, subtract the width when it fits
        always_comb begin
            logic [WIDTH_BITS:0] t;
            n_rem = w_rem_in;
            n_dvd = w_dvd_in;
            for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
                t     = {n_rem, n_dvd[DVW-1]};
                n_dvd = n_dvd << 1;
                if (t >= {1'b0, i_width}) begin
                    n_rem = WIDTH_BITS'(t - {1'b0, i_width});
                end else begin
                    n_rem = WIDTH_BITS'(t);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_rem[j]  <= n_rem;
                r_dvd[j]  <= n_dvd;
                r_side[j] <= w_side_in;
            end
        end
    end

    assign o_rem  = r_rem[NUM_DIV-1];
    assign o_side = r_side[NUM_DIV-1];

endmodule

// ----- hdl/cbp_ycc.sv -----
// Marker test, bar colour selection and RGB to YCbCr matrix in four stages.
// Uses cbp_pkg for coefficients, colour tables and the result type.

module cbp_ycc
    import cbp_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MARKER_WIDTH = DEF_MARKER_WIDTH
) (
    input  logic                                i_clk,
    input  logic [3:0]                          i_en,
    input  logic                                i_use_bt601,
    input  logic                                i_no_offset,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      i_start,
    input  t_side                               i_side,
    output t_out                                o_data
);

    localparam int EW   = $clog2(MAX_WIDTH + MARKER_WIDTH);
    localparam int CMPW = (EW > COL_W) ? EW : COL_W;

    typedef struct packed {
        t_rgb rgb_y;
        t_rgb rgb_c;
        logic mark_y;
        logic cv;
    } t_sel;

    typedef struct packed {
        logic mark_y;
        logic cv;
    } t_flags;

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    t_sel   n_sel, r_sel;
    t_prod  n_prod [3][3];
    t_prod  r_prod [3][3];
    t_flags r_mul_flags, r_sum_flags;
    t_acc   n_acc  [3];
    t_acc   r_acc  [3];
    t_out   r_out;

    function automatic logic [SAMPLE_W-1:0] clamp_sample(input t_acc a);
        t_acc         rnd;
        t_acc         v;
        logic [SAMPLE_W-1:0] s;
        rnd = a + ROUND_HALF;
        v   = rnd >>> FRAC_BITS;
        if (a < 0) begin
            s = '0;
        end else if (v > t_acc'(SAMPLE_MAX)) begin
            s = SAMPLE_MAX;
        end else begin
            s = SAMPLE_W'(v);
        end
        return s;
    endfunction

    // Stage 1: marker window and bar colours; chroma uses the pair's left pixel
    always_comb begin
        logic [CMPW-1:0] x, sx, lo, hi;
        logic            mark_c;
        x      = CMPW'(i_side.col);
        sx     = CMPW'({i_side.col[COL_W-1:1], 1'b0});
        lo     = CMPW'(i_start);
        hi     = lo + CMPW'(MARKER_WIDTH);
        mark_c = (sx >= lo) && (sx < hi);
        n_sel.mark_y = (x >= lo) && (x < hi);
        n_sel.rgb_y  = bar_rgb(i_side.bar_y);
        n_sel.rgb_c  = mark_c ? {LEVEL_HI, LEVEL_HI, LEVEL_HI} : bar_rgb(i_side.bar_c);
        n_sel.cv     = i_side.cv;
    end

    // Stage 2: one coefficient times one channel level per product
    always_comb begin
        logic [SAMPLE_W-1:0] lvl;
        for (int c = 0; c < 3; c++) begin
            for (int ch = 0; ch < 3; ch++) begin
                lvl = (c == 0) ? r_sel.rgb_y[ch] : r_sel.rgb_c[ch];
                n_prod[c][ch] = PROD_W'(COEF[i_use_bt601][c][ch])
                                * PROD_W'($signed({1'b0, lvl}));
            end
        end
    end

    // Stage 3: offset plus the three products
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_acc[c] = ((c == 0) ? (i_no_offset ? t_acc'(0) : OFF_LUMA) : OFF_CHROMA)
                       + t_acc'(r_prod[c][0]) + t_acc'(r_prod[c][1])
                       + t_acc'(r_prod[c][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sel <= n_sel;
        end
        if (i_en[1]) begin
            r_prod      <= n_prod;
            r_mul_flags <= '{mark_y: r_sel.mark_y, cv: r_sel.cv};
        end
        if (i_en[2]) begin
            r_acc       <= n_acc;
            r_sum_flags <= r_mul_flags;
        end
        // Stage 4: round, clamp, override luma under the marker
        if (i_en[3]) begin
            r_out.luma         <= r_sum_flags.mark_y ? MARKER_LUMA : clamp_sample(r_acc[0]);
            r_out.chroma_blue  <= clamp_sample(r_acc[1]);
            r_out.chroma_red   <= clamp_sample(r_acc[2]);
            r_out.chroma_valid <= r_sum_flags.cv;
        end
    end

    assign o_data = r_out;

endmodule

// ----- hdl/color_bar_pattern_generator_top.sv -----
// Top level of the eight-bar YCbCr colour test pattern generator.
// Depends on cbp_pkg, cbp_pipe_ctrl, cbp_mod_div and cbp_ycc.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in)
//  out     | output    | o_out_valid / i_out_stall| o_out_data (t_out)
//  cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the output is not stalled; an accepted item
// passes capture, product, ND remainder and four colour stages, where ND is the
// number of remainder stages (product bits / 4, rounded up): 8 at defaults.
// The frame-by-step product mod line width runs 4 bits per stage and sets the depth.
// Synchronous active-low reset clears valid bits and configuration only.
// Stalls ripple back stage by stage; empty stages keep filling while the output waits.

module color_bar_pattern_generator_top
    import cbp_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MARKER_WIDTH = DEF_MARKER_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in                    i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out                   o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [LINE_W-1:0]      i_cfg_data
);

    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int CW       = (WW > LINE_W) ? WW : LINE_W;
    localparam int STW      = $clog2(MAX_WIDTH / STEP_DIV + 2);
    localparam int PW       = FRAME_W + STW;
    localparam int ND       = (PW + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
    localparam int NS       = ND + 6;
    localparam int DIV_LAST = ND + 1;
    localparam int BW0      = $clog2(7 * MAX_WIDTH + 1);
    localparam int BW       = (BW0 > COL_W + 3) ? BW0 : COL_W + 3;

    logic [LINE_W-1:0] r_line_width;
    logic              r_use_bt601;
    logic              r_no_offset;
    logic [STW-1:0]    r_step;
    logic [STW-1:0]    n_step;

    logic [WW-1:0]     w_eff;
    logic [WW+RECIP_W-1:0] w_recip;

    logic [NS-1:0]     w_vld;
    logic [NS-1:0]     w_en;

    t_in               r_s0;
    logic [PW-1:0]     r_prod;
    t_side             r_side;
    t_side             n_side;

    logic [WW-1:0]     w_start;
    t_side             w_div_side;

    function automatic logic [2:0] bar_of(input logic [COL_W-1:0] x,
                                          input logic [WW-1:0] w);
        logic [BW-1:0] x8;
        logic [2:0]    b;
        x8 = BW'({x, 3'b000});
        b  = '0;
        // Count the bar boundaries k*w at or below 8x; saturates at 7
        for (int k = 1; k < 8; k++) begin
            if (x8 >= BW'(k) * BW'(w)) begin
                b = b + 3'd1;
            end
        end
        return b;
    endfunction

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RST;
            r_use_bt601  <= 1'b0;
            r_no_offset  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LINE_WIDTH: r_line_width <= i_cfg_data;
                CFG_USE_BT601:  r_use_bt601  <= i_cfg_data[0];
                CFG_NO_OFFSET:  r_no_offset  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Effective width: zero reads as one, oversize clamps to the maximum
    always_comb begin
        logic [CW-1:0] lw;
        lw = CW'(r_line_width);
        if (lw == '0) begin
            w_eff = WW'(1);
        end else if (lw > CW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(lw);
        end
    end

    assign w_recip = (WW + RECIP_W)'(w_eff) * (WW + RECIP_W)'(RECIP_STEP);
    assign n_step  = STW'(w_recip >> RECIP_SHIFT) + STW'(1);

    // Step follows the configuration; refreshed every cycle
    always_ff @(posedge i_clk) begin
        r_step <= n_step;
    end

    cbp_pipe_ctrl #(
        .NUM_STAGES (NS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_vld       (w_vld),
        .o_en        (w_en)
    );

    always_comb begin
        n_side.col   = r_s0.column;
        n_side.cv    = !r_s0.row[0] && !r_s0.column[0];
        n_side.bar_y = bar_of(r_s0.column, w_eff);
        n_side.bar_c = bar_of({r_s0.column[COL_W-1:1], 1'b0}, w_eff);
    end

    // Stage 0 captures the item; stage 1 forms frame*step and the bar indexes
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s0 <= i_in_data;
        end
        if (w_en[1]) begin
            r_prod <= PW'(r_s0.frame_number) * PW'(r_step);
            r_side <= n_side;
        end
    end

    cbp_mod_div #(
        .PROD_BITS  (PW),
        .WIDTH_BITS (WW),
        .NUM_DIV    (ND)
    ) u_div (
        .i_clk   (i_clk),
        .i_en    (w_en[DIV_LAST:2]),
        .i_width (w_eff),
        .i_prod  (r_prod),
        .i_side  (r_side),
        .o_rem   (w_start),
        .o_side  (w_div_side)
    );

    cbp_ycc #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MARKER_WIDTH (MARKER_WIDTH)
    ) u_ycc (
        .i_clk        (i_clk),
        .i_en         (w_en[NS-1:NS-4]),
        .i_use_bt601  (r_use_bt601),
        .i_no_offset  (r_no_offset),
        .i_start      (w_start),
        .i_side       (w_div_side),
        .o_data       (o_out_data)
    );

    assign o_out_valid = w_vld[NS-1];

    // Back-pressure only ever comes from a held result
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // Marker start leaves the remainder unit below the line width
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[DIV_LAST] |-> (w_start < w_eff))
        else $error("marker start not reduced below width");

    // An accepted item occupies the first stage on the next cycle
    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> w_vld[0])
        else $error("accepted item lost at pipeline entry");

    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_eff != '0) && (WW'(MAX_WIDTH) >= w_eff) && (r_step != '0))
        else $error("effective width or marker step out of range");

endmodule
